// ----- sv/obstacle_avoidance_drive_fsm_defines.svh -----
// Assertion macros shared by the drive sequencer RTL.
`ifndef OBSTACLE_AVOIDANCE_DRIVE_FSM_DEFINES_SVH
`define OBSTACLE_AVOIDANCE_DRIVE_FSM_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define OAD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define OAD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/oad_pkg.sv -----
package oad_pkg;

    localparam int unsigned SPEED_W = 7;
    localparam int unsigned DIST_W  = 8;
    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned MODE_W  = 4;

    typedef logic [SPEED_W-1:0]        t_speed;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [TICK_W-1:0]         t_ticks;
    typedef logic [MODE_W-1:0]         t_mode_code;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FORWARD_SPEED    = 2'd0,
        CFG_SIDE_THRESHOLD   = 2'd1,
        CFG_CENTER_THRESHOLD = 2'd2,
        CFG_WAIT_TICKS       = 2'd3
    } t_cfg_idx;

    localparam t_speed MAX_SPEED          = 7'd100;
    localparam t_speed RST_FORWARD_SPEED  = 7'd10;
    localparam t_dist  RST_SIDE_THRESHOLD = 8'd30;
    localparam t_dist  RST_CENTER_THRESH  = 8'd20;
    localparam t_ticks RST_WAIT_TICKS     = 16'd1000;
    localparam t_ticks TICK_MAX           = 16'hFFFF;

endpackage

// ----- sv/obstacle_avoidance_drive_fsm.sv -----
// Channel | Direction | Handshake                    | Payload
// --------+-----------+------------------------------+-------------------------------------
// in      | sink      | i_in_valid / o_in_ready      | i_command, i_dist_* (five readings)
// out     | source    | o_out_valid / i_out_ready    | o_right_drive, o_left_drive, o_mode
// cfg     | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Every item yields exactly one result: the item lands in the input register when accepted,
// and its result is loaded from there into the state/result register once the result slot is
// free, raising o_out_valid. One item per cycle is sustained back to back unless the output stalls.
// Reset (synchronous, active low) restores the default configuration, wait-entry mode,
// zero tick count and zero drive levels. A stall on the output holds the result; the input
// register takes one more item, then o_in_ready drops until the result is taken.
module obstacle_avoidance_drive_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  oad_pkg::t_dist       i_dist_right,
    input  oad_pkg::t_dist       i_dist_center,
    input  oad_pkg::t_dist       i_dist_left,
    input  oad_pkg::t_dist       i_dist_far_right,
    input  oad_pkg::t_dist       i_dist_far_left,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output oad_pkg::t_level      o_right_drive,
    output oad_pkg::t_level      o_left_drive,
    output oad_pkg::t_mode_code  o_mode,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  oad_pkg::t_cfg_idx    i_cfg_index,
    input  oad_pkg::t_ticks      i_cfg_data
);
    import oad_pkg::*;

    `include "obstacle_avoidance_drive_fsm_defines.svh"

    // Drive modes: even = action entry (loads levels), odd = action in progress.
    typedef enum logic [MODE_W-1:0] {
        WAIT_ENTRY   = 4'd0,
        WAIT_RUN     = 4'd1,
        FWD_ENTRY    = 4'd2,
        FWD_RUN      = 4'd3,
        LEFT_ENTRY   = 4'd4,
        LEFT_RUN     = 4'd5,
        RIGHT_ENTRY  = 4'd6,
        RIGHT_RUN    = 4'd7,
        SPINL_ENTRY  = 4'd8,
        SPINL_RUN    = 4'd9,
        SPINR_ENTRY  = 4'd10,
        SPINR_RUN    = 4'd11
    } t_mode;

    // Configuration registers.
    t_speed r_forward_speed;
    t_dist  r_side_threshold;
    t_dist  r_center_threshold;
    t_ticks r_wait_ticks;

    // Input register.
    logic   r_in_valid;
    logic   r_in_command;
    t_dist  r_in_right;
    t_dist  r_in_center;
    t_dist  r_in_left;
    t_dist  r_in_far_right;
    t_dist  r_in_far_left;

    // Sequencer state; the mode and levels double as the result register.
    t_mode  r_mode;
    t_ticks r_tick_count;
    t_level r_right_level;
    t_level r_left_level;
    logic   r_out_valid;

    t_mode  n_mode;
    t_ticks n_tick_count;
    t_level n_right_level;
    t_level n_left_level;

    logic   out_free;
    logic   advance;
    t_speed speed;
    t_level level_full;
    t_level level_half;
    logic   obst_right;
    logic   obst_left;
    logic   obst_front;
    t_mode  action;

    // Terms for the checks at the end.
    logic   chk_tick;
    logic   chk_entry;
    logic   chk_run;
    logic   pipe_full;

    // Advance the input register into the state whenever the result slot is free.
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_right_drive = r_right_level;
    assign o_left_drive  = r_left_level;
    assign o_mode        = r_mode;

    // Clamp speed to 100 %; forward level is 2*speed half-percent, spin level is speed.
    assign speed      = (r_forward_speed > MAX_SPEED) ? MAX_SPEED : r_forward_speed;
    assign level_full = $signed({1'b0, speed, 1'b0});
    assign level_half = $signed({2'b00, speed});

    // Obstacle classes; a reading equal to its threshold is neither below nor above.
    assign obst_right = (r_in_right < r_side_threshold || r_in_far_right < r_side_threshold)
                        && r_in_center > r_center_threshold && r_in_left > r_side_threshold;
    assign obst_left  = r_in_right > r_side_threshold && r_in_center > r_center_threshold
                        && (r_in_left < r_side_threshold || r_in_far_left < r_side_threshold);
    assign obst_front = r_in_center < r_center_threshold;

    always_comb begin
        priority if (obst_right) begin
            action = LEFT_ENTRY;
        end else if (obst_left) begin
            action = RIGHT_ENTRY;
        end else if (obst_front) begin
            action = SPINL_ENTRY;
        end else begin
            action = FWD_ENTRY;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_tick_count  = r_tick_count;
        n_right_level = r_right_level;
        n_left_level  = r_left_level;
        if (!r_in_command) begin
            // Tick: count up, hold at full scale.
            if (r_tick_count != TICK_MAX) begin
                n_tick_count = r_tick_count + t_ticks'(1);
            end
        end else begin
            unique case (r_mode)
                WAIT_ENTRY: begin
                    // Count restarts at zero, so the exit test cannot pass here.
                    n_tick_count  = '0;
                    n_right_level = '0;
                    n_left_level  = '0;
                    n_mode        = WAIT_RUN;
                end
                WAIT_RUN: begin
                    if (r_tick_count > r_wait_ticks) begin
                        n_mode = FWD_ENTRY;
                    end
                end
                FWD_ENTRY: begin
                    n_right_level = level_full;
                    n_left_level  = level_full;
                    n_mode        = FWD_RUN;
                end
                LEFT_ENTRY: begin
                    n_right_level = level_full;
                    n_left_level  = '0;
                    n_mode        = LEFT_RUN;
                end
                RIGHT_ENTRY: begin
                    n_right_level = '0;
                    n_left_level  = level_full;
                    n_mode        = RIGHT_RUN;
                end
                SPINL_ENTRY: begin
                    n_right_level = level_half;
                    n_left_level  = -level_half;
                    n_mode        = SPINL_RUN;
                end
                SPINR_ENTRY: begin
                    n_right_level = -level_half;
                    n_left_level  = level_half;
                    n_mode        = SPINR_RUN;
                end
                FWD_RUN, LEFT_RUN, RIGHT_RUN, SPINL_RUN, SPINR_RUN: begin
                    // Switch only when the chosen action is not the running one.
                    if (action != t_mode'({r_mode[MODE_W-1:1], 1'b0})) begin
                        n_mode = action;
                    end
                end
                default: begin
                    n_mode = WAIT_ENTRY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_speed    <= RST_FORWARD_SPEED;
            r_side_threshold   <= RST_SIDE_THRESHOLD;
            r_center_threshold <= RST_CENTER_THRESH;
            r_wait_ticks       <= RST_WAIT_TICKS;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_mode             <= WAIT_ENTRY;
            r_tick_count       <= '0;
            r_right_level      <= '0;
            r_left_level       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FORWARD_SPEED:    r_forward_speed    <= i_cfg_data[SPEED_W-1:0];
                    CFG_SIDE_THRESHOLD:   r_side_threshold   <= i_cfg_data[DIST_W-1:0];
                    CFG_CENTER_THRESHOLD: r_center_threshold <= i_cfg_data[DIST_W-1:0];
                    CFG_WAIT_TICKS:       r_wait_ticks       <= i_cfg_data;
                    default:              r_wait_ticks       <= r_wait_ticks;
                endcase
            end
            // Input register: load on accept, drop once moved into the state.
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // Result register: hold while stalled.
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_mode        <= n_mode;
                r_tick_count  <= n_tick_count;
                r_right_level <= n_right_level;
                r_left_level  <= n_left_level;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Input payload register: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_command   <= i_command;
            r_in_right     <= i_dist_right;
            r_in_center    <= i_dist_center;
            r_in_left      <= i_dist_left;
            r_in_far_right <= i_dist_far_right;
            r_in_far_left  <= i_dist_far_left;
        end
    end

    assign chk_tick  = advance && !r_in_command;
    assign chk_entry = advance && r_in_command && !r_mode[0] && (r_mode <= SPINR_ENTRY);
    assign chk_run   = advance && r_mode[0];
    assign pipe_full = r_in_valid && r_out_valid && !i_out_ready;

    `OAD_ASSERT(a_tick_keeps_mode, chk_tick |=> $stable(r_mode), "tick item moved the mode")
    `OAD_ASSERT(a_entry_to_run, chk_entry |=> r_mode == $past(r_mode) + 4'd1, "entry skipped run")
    `OAD_ASSERT(a_run_keeps_right, chk_run |=> $stable(r_right_level), "right level moved")
    `OAD_ASSERT(a_run_keeps_left, chk_run |=> $stable(r_left_level), "left level moved")
    `OAD_ASSERT_ALWAYS(a_ready_only_when_full, !o_in_ready |-> pipe_full, "input stalled early")

endmodule
